[rtl/rpc_pkg.sv]
// Shared types, register indexes and reset values for the RGBA pixel compositor.
// Used by rpc_mix and rgba_pixel_compositor; depends on nothing.
`default_nettype none

package rpc_pkg;

  typedef logic [31:0] pix_t;
  typedef logic [1:0]  bidx_t;
  typedef logic [7:0]  chan_t;

  typedef enum logic [2:0] {
    REG_SRC_MAP       = 3'd0,
    REG_SRC_HAS_ALPHA = 3'd1,
    REG_DST_MAP       = 3'd2,
    REG_DST_HAS_ALPHA = 3'd3,
    REG_BLEND_EN      = 3'd4,
    REG_FILL          = 3'd5
  } cfg_reg_e;

  localparam chan_t RST_SRC_MAP = 8'd228;
  localparam chan_t RST_DST_MAP = 8'd228;
  localparam pix_t  RST_FILL    = 32'd255;
  localparam chan_t ALPHA_OPAQUE = 8'd255;

  function automatic chan_t byte_of(pix_t w, bidx_t i);
    return w[{i, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

[rtl/rpc_mix.sv]
// One channel of the alpha blend: (a*s + (255-a)*d)/255 written into one byte of a word.
// Depends on rpc_pkg.
`default_nettype none

module rpc_mix (
  input  rpc_pkg::pix_t  word_i,
  input  rpc_pkg::bidx_t idx_i,
  input  rpc_pkg::chan_t alpha_i,
  input  rpc_pkg::chan_t color_i,
  input  logic           en_i,
  output rpc_pkg::pix_t  word_o
);
  import rpc_pkg::*;

  chan_t       dst_byte;
  chan_t       inv_alpha;
  logic [15:0] sum;
  logic [15:0] rnd;
  chan_t       mixed;

  assign dst_byte  = byte_of(word_i, idx_i);
  assign inv_alpha = ALPHA_OPAQUE - alpha_i;
  assign sum       = 16'(alpha_i) * 16'(color_i) + 16'(inv_alpha) * 16'(dst_byte);
  // divide by 255, exact for sums up to 255*255
  assign rnd       = sum + 16'd1 + {8'd0, sum[15:8]};
  assign mixed     = rnd[15:8];

  always_comb begin
    word_o = word_i;
    if (en_i) begin
      word_o[{idx_i, 3'b000} +: 8] = mixed;
    end
  end

endmodule

`default_nettype wire

[rtl/rgba_pixel_compositor.sv]
// Top level of the RGBA pixel compositor: config registers, mode decode, three blend stages.
// Depends on rpc_pkg and rpc_mix.
//
//   channel  | direction | signals
//   ---------+-----------+--------------------------------------------------
//   in       | sink      | in_valid_i, in_ready_o, action_i, src_pixel_i, dst_pixel_i
//   out      | source    | out_valid_o, out_ready_i, out_pixel_o
//   cfg      | sink      | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One pixel per clock sustained while the output is not stalled.
// Four registered stages: input, red mix, green mix, blue mix into the output register.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset clears the stage valids and loads the register reset values.
`default_nettype none

module rgba_pixel_compositor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  rpc_pkg::pix_t cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          action_i,
  input  rpc_pkg::pix_t src_pixel_i,
  input  rpc_pkg::pix_t dst_pixel_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rpc_pkg::pix_t out_pixel_o
);
  import rpc_pkg::*;

  chan_t src_map_q, dst_map_q;
  logic  src_has_alpha_q, dst_has_alpha_q, blend_en_q;
  pix_t  fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_map_q       <= RST_SRC_MAP;
      src_has_alpha_q <= 1'b1;
      dst_map_q       <= RST_DST_MAP;
      dst_has_alpha_q <= 1'b1;
      blend_en_q      <= 1'b0;
      fill_q          <= RST_FILL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_MAP:       src_map_q       <= cfg_data_i[7:0];
        REG_SRC_HAS_ALPHA: src_has_alpha_q <= cfg_data_i[0];
        REG_DST_MAP:       dst_map_q       <= cfg_data_i[7:0];
        REG_DST_HAS_ALPHA: dst_has_alpha_q <= cfg_data_i[0];
        REG_BLEND_EN:      blend_en_q      <= cfg_data_i[0];
        REG_FILL:          fill_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic vin_q, v1_q, v2_q, vout_q;

  assign adv         = !vout_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q  <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vout_q <= 1'b0;
    end else if (adv) begin
      vin_q  <= in_valid_i;
      v1_q   <= vin_q;
      v2_q   <= v1_q;
      vout_q <= v2_q;
    end
  end

  // input stage
  logic in_act_q;
  pix_t in_src_q, in_dst_q;

  // decode
  logic  blend_copy, pass_mode, fill_pack, blend0;
  chan_t alpha0, cr0, cg0, cb0, fa;
  pix_t  pack_word, word0;

  assign fa         = fill_q[7:0];
  assign blend_copy = !in_act_q && blend_en_q && src_has_alpha_q;
  assign pass_mode  = !in_act_q && !blend_copy;
  assign fill_pack  = in_act_q && (!dst_has_alpha_q || fa == ALPHA_OPAQUE);
  assign blend0     = blend_copy || (in_act_q && !fill_pack);

  assign alpha0 = in_act_q ? fa           : byte_of(in_src_q, src_map_q[7:6]);
  assign cr0    = in_act_q ? fill_q[31:24] : byte_of(in_src_q, src_map_q[1:0]);
  assign cg0    = in_act_q ? fill_q[23:16] : byte_of(in_src_q, src_map_q[3:2]);
  assign cb0    = in_act_q ? fill_q[15:8]  : byte_of(in_src_q, src_map_q[5:4]);

  // overlapping byte indexes add with carry into higher bytes
  assign pack_word = (32'(cr0) << {dst_map_q[1:0], 3'b000})
                   + (32'(cg0) << {dst_map_q[3:2], 3'b000})
                   + (32'(cb0) << {dst_map_q[5:4], 3'b000})
                   + ((dst_has_alpha_q ? 32'(fa) : 32'd0) << {dst_map_q[7:6], 3'b000});

  always_comb begin
    priority if (pass_mode) begin
      word0 = in_src_q;
    end else if (fill_pack) begin
      word0 = pack_word;
    end else begin
      word0 = in_dst_q;
    end
  end

  pix_t  p1_word_d, p1_word_q, p2_word_d, p2_word_q, out_d, out_q;
  logic  p1_blend_q, p2_blend_q;
  chan_t p1_alpha_q, p1_cg_q, p1_cb_q, p2_alpha_q, p2_cb_q;

  rpc_mix u_mix_r (
    .word_i  (word0),
    .idx_i   (dst_map_q[1:0]),
    .alpha_i (alpha0),
    .color_i (cr0),
    .en_i    (blend0),
    .word_o  (p1_word_d)
  );

  rpc_mix u_mix_g (
    .word_i  (p1_word_q),
    .idx_i   (dst_map_q[3:2]),
    .alpha_i (p1_alpha_q),
    .color_i (p1_cg_q),
    .en_i    (p1_blend_q),
    .word_o  (p2_word_d)
  );

  rpc_mix u_mix_b (
    .word_i  (p2_word_q),
    .idx_i   (dst_map_q[5:4]),
    .alpha_i (p2_alpha_q),
    .color_i (p2_cb_q),
    .en_i    (p2_blend_q),
    .word_o  (out_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_act_q   <= action_i;
      in_src_q   <= src_pixel_i;
      in_dst_q   <= dst_pixel_i;
      p1_word_q  <= p1_word_d;
      p1_blend_q <= blend0;
      p1_alpha_q <= alpha0;
      p1_cg_q    <= cg0;
      p1_cb_q    <= cb0;
      p2_word_q  <= p2_word_d;
      p2_blend_q <= p1_blend_q;
      p2_alpha_q <= p1_alpha_q;
      p2_cb_q    <= p1_cb_q;
      out_q      <= out_d;
    end
  end

  assign out_pixel_o = out_q;

  a_pass_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vin_q && pass_mode |=> p1_word_q == $past(in_src_q))
    else $error("plain copy altered the source word");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({vin_q, v1_q, v2_q}))
    else $error("pipeline moved while output stalled");

  a_noblend_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v1_q && !p1_blend_q |=> p2_word_q == $past(p1_word_q))
    else $error("word changed in a stage with blending off");

  a_fill_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vin_q && in_act_q && !dst_has_alpha_q |=> !p1_blend_q)
    else $error("fill into alpha-less destination was blended");

endmodule

`default_nettype wire
